[design/pas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Shared constants, codes and command/status types of the polyline sampler.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int COORD_W    = 32;
    localparam int LEN_W      = 48;
    localparam int POS_W      = 17;
    localparam int ENTRY_W    = LEN_W + 2 * COORD_W;

    localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [LEN_W-1:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_LOAD      = 2'd1,
        OP_EVAL_IDX  = 2'd2,
        OP_EVAL_ARC  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RD_LAST,
        RD_ZERO,
        RD_MID,
        RD_LO,
        RD_HI
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ZERO,
        RES_VTX,
        RES_LERP
    } res_sel_t;

    typedef struct packed {
        logic [LEN_W-1:0]   cum;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } entry_t;

    typedef struct packed {
        logic     latch;
        logic     clear_cnt;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     sq;
        logic     sum_init;
        logic     sqrt_step;
        logic     write_vtx;
        logic     save_total;
        logic     imul;
        logic     amul;
        logic     search_init;
        logic     search_upd;
        logic     capture_a;
        logic     div_init;
        logic     div_step;
        logic     mul;
        res_sel_t res_sel;
        status_t  res_status;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic cnt_zero;
        logic full;
        logic lt2;
        logic total_zero;
        logic t_zero;
        logic t_one;
        logic target_ge;
        logic span_gt1;
        logic sqrt_last;
        logic div_last;
        logic seg_bad;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[design/pas_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_if
// Valid/ready channels: input items and result items of the sampler.
// ----------------------------------------------------------------------------
interface pas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic [16:0] position;

    modport source (output valid, op, in_x, in_y, position, input ready);
    modport sink   (input valid, op, in_x, in_y, position, output ready);
endinterface

interface pas_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]  status;

    modport source (output valid, out_x, out_y, status, input ready);
    modport sink   (input valid, out_x, out_y, status, output ready);
endinterface
`default_nettype wire

[design/pas_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[design/pas_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_datapath
// Vertex table, square root, search, divider and interpolation registers.
// ----------------------------------------------------------------------------
module pas_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pas_pkg::dp_cmd_t   cmd,
    output pas_pkg::dp_status_t     sts,
    input  wire logic               cfg_write,
    input  wire logic               cfg_data,
    pas_in_if.sink                  in_ch,
    pas_out_if.source               out_ch
);
    import pas_pkg::*;

    // Control state.
    logic [CNT_W-1:0] cnt_reg;
    logic             rev_reg;
    logic             ovalid_reg;

    // Item and working registers.
    op_t                 op_reg;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [POS_W-1:0]    t_reg;
    logic [63:0]         a2_reg, b2_reg;
    logic [65:0]         sum_reg;
    logic [35:0]         rem_reg;
    logic [32:0]         root_reg;
    logic [5:0]          step_reg;
    logic [LEN_W-1:0]    s0_reg, total_reg, den_reg, divr_reg;
    logic [LEN_W:0]      target_reg;
    logic [IDX_W-1:0]    lo_reg, hi_reg;
    logic [15:0]         q_reg;
    logic [COORD_W-1:0]  ax_reg, ay_reg;
    logic signed [49:0]  px_reg, py_reg;
    logic [COORD_W-1:0]  resx_reg, resy_reg;
    status_t             resst_reg;
    logic [COORD_W-1:0]  ox_reg, oy_reg;
    status_t             ost_reg;

    entry_t           rd;
    entry_t           wr;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] mid;
    logic [CNT_W-1:0] last9;

    assign last9 = cnt_reg - CNT_W'(1);
    assign mid   = lo_reg + IDX_W'((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_LAST: raddr = last9[IDX_W-1:0];
            RD_ZERO: raddr = '0;
            RD_MID:  raddr = mid;
            RD_LO:   raddr = lo_reg;
            RD_HI:   raddr = hi_reg;
            default: raddr = '0;
        endcase
    end

    // Saturating running length.
    logic [LEN_W:0]   len_sum;
    logic [LEN_W-1:0] len_new;
    assign len_sum = {1'b0, s0_reg} + (LEN_W+1)'(root_reg);
    assign len_new = (cnt_reg == '0) ? '0 : (len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0]);
    assign wr = '{cum: len_new, y: y_reg, x: x_reg};

    pas_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
        .clk   (clk),
        .we    (cmd.write_vtx),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (wr),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rd)
    );

    // Absolute coordinate differences to the previous vertex.
    logic [32:0] dxs, dys, dxa, dya;
    assign dxs = {x_reg[31], x_reg} - {rd.x[31], rd.x};
    assign dys = {y_reg[31], y_reg} - {rd.y[31], rd.y};
    assign dxa = dxs[32] ? (33'd0 - dxs) : dxs;
    assign dya = dys[32] ? (33'd0 - dys) : dys;

    // One restoring square-root step.
    logic [35:0] rem_sh, trial;
    assign rem_sh = {rem_reg[33:0], sum_reg[65:64]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // Position after clamping and mirroring.
    logic [POS_W-1:0] pos_c, pos_t;
    assign pos_c = (in_ch.position > ONE_Q16) ? ONE_Q16 : in_ch.position;
    assign pos_t = rev_reg ? (ONE_Q16 - pos_c) : pos_c;

    // Index-mode segment and fraction.
    logic [24:0]      u_idx;
    logic [CNT_W-1:0] i_idx, i_cl;
    assign u_idx = t_reg[15:0] * last9;
    assign i_idx = u_idx[24:16];
    assign i_cl  = (i_idx > cnt_reg - CNT_W'(2)) ? cnt_reg - CNT_W'(2) : i_idx;

    // Arc-length target: position times the integer and fraction halves of the total.
    logic [LEN_W-1:0] tgt_hi;
    logic [31:0]      tgt_lo;
    logic [LEN_W:0]   tgt;
    assign tgt_hi = t_reg[15:0] * total_reg[47:16];
    assign tgt_lo = t_reg[15:0] * total_reg[15:0];
    assign tgt    = (LEN_W+1)'(tgt_hi) + (LEN_W+1)'(tgt_lo[31:16]);

    // One restoring division step.
    logic [LEN_W:0] divr_sh;
    assign divr_sh = {divr_reg, 1'b0};

    // Interpolation.
    logic signed [32:0] dxl, dyl;
    logic signed [50:0] rx, ry;
    assign dxl = $signed({rd.x[31], rd.x}) - $signed({ax_reg[31], ax_reg});
    assign dyl = $signed({rd.y[31], rd.y}) - $signed({ay_reg[31], ay_reg});
    assign rx  = (51'(px_reg) + 51'sd32768) >>> 16;
    assign ry  = (51'(py_reg) + 51'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rev_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                rev_reg <= cfg_data;
            end
            if (cmd.clear_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.write_vtx)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= op_t'(in_ch.op);
            x_reg  <= in_ch.in_x;
            y_reg  <= in_ch.in_y;
            t_reg  <= pos_t;
        end
        if (cmd.sq)
        begin
            a2_reg <= dxa[31:0] * dxa[31:0];
            b2_reg <= dya[31:0] * dya[31:0];
            s0_reg <= rd.cum;
        end
        if (cmd.sum_init)
        begin
            sum_reg  <= {1'b0, 65'(a2_reg) + 65'(b2_reg)};
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= 6'd32;
        end
        if (cmd.sqrt_step)
        begin
            sum_reg  <= {sum_reg[63:0], 2'b00};
            step_reg <= step_reg - 6'd1;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end
        if (cmd.save_total)
        begin
            total_reg <= rd.cum;
        end
        if (cmd.imul)
        begin
            lo_reg <= i_cl[IDX_W-1:0];
            hi_reg <= i_cl[IDX_W-1:0] + IDX_W'(1);
            q_reg  <= u_idx[15:0];
        end
        if (cmd.amul)
        begin
            target_reg <= tgt;
        end
        if (cmd.search_init)
        begin
            lo_reg <= '0;
            hi_reg <= last9[IDX_W-1:0];
        end
        if (cmd.search_upd)
        begin
            if ({1'b0, rd.cum} <= target_reg)
            begin
                lo_reg <= mid;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.capture_a)
        begin
            ax_reg <= rd.x;
            ay_reg <= rd.y;
            s0_reg <= rd.cum;
        end
        if (cmd.div_init)
        begin
            divr_reg <= target_reg[LEN_W-1:0] - s0_reg;
            den_reg  <= rd.cum - s0_reg;
            q_reg    <= '0;
            step_reg <= 6'd15;
        end
        if (cmd.div_step)
        begin
            step_reg <= step_reg - 6'd1;
            if (divr_sh >= {1'b0, den_reg})
            begin
                divr_reg <= LEN_W'(divr_sh - {1'b0, den_reg});
                q_reg    <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                divr_reg <= divr_sh[LEN_W-1:0];
                q_reg    <= {q_reg[14:0], 1'b0};
            end
        end
        if (cmd.mul)
        begin
            px_reg <= dxl * $signed({1'b0, q_reg});
            py_reg <= dyl * $signed({1'b0, q_reg});
        end
        unique case (cmd.res_sel)
            RES_NONE:
            begin
            end
            RES_ZERO:
            begin
                resx_reg  <= '0;
                resy_reg  <= '0;
                resst_reg <= cmd.res_status;
            end
            RES_VTX:
            begin
                resx_reg  <= rd.x;
                resy_reg  <= rd.y;
                resst_reg <= cmd.res_status;
            end
            RES_LERP:
            begin
                resx_reg  <= ax_reg + rx[31:0];
                resy_reg  <= ay_reg + ry[31:0];
                resst_reg <= cmd.res_status;
            end
            default:
            begin
            end
        endcase
        if (cmd.emit)
        begin
            ox_reg  <= resx_reg;
            oy_reg  <= resy_reg;
            ost_reg <= resst_reg;
        end
    end

    assign out_ch.valid  = ovalid_reg;
    assign out_ch.out_x  = ox_reg;
    assign out_ch.out_y  = oy_reg;
    assign out_ch.status = ost_reg;

    assign sts.op         = op_reg;
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.full       = (cnt_reg >= CNT_W'(MAX_POINTS));
    assign sts.lt2        = (cnt_reg < CNT_W'(2));
    assign sts.total_zero = (rd.cum == '0);
    assign sts.t_zero     = (t_reg == '0);
    assign sts.t_one      = (t_reg >= ONE_Q16);
    assign sts.target_ge  = (target_reg >= {1'b0, total_reg});
    assign sts.span_gt1   = ((hi_reg - lo_reg) > IDX_W'(1));
    assign sts.sqrt_last  = (step_reg == '0);
    assign sts.div_last   = (step_reg == '0);
    assign sts.seg_bad    = (rd.cum <= s0_reg) || (target_reg < {1'b0, s0_reg});
    assign sts.out_free   = !ovalid_reg || out_ch.ready;

endmodule
`default_nettype wire

[design/pas_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ctrl
// Sequencer that steps the datapath through load and evaluation.
// ----------------------------------------------------------------------------
module pas_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pas_pkg::dp_status_t  sts,
    output pas_pkg::dp_cmd_t          cmd
);
    import pas_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_LSQ, S_LSUM, S_LSQRT, S_LWRITE,
        S_ETOT, S_IMUL, S_AMUL, S_ACHK, S_SRCH, S_SCMP,
        S_RLO, S_RHI, S_ADIV0, S_DIV, S_MUL, S_LERP, S_EVTX, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_ZERO;
        cmd.res_sel = RES_NONE;
        cmd.res_status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear_cnt = 1'b1;
                        cmd.res_sel   = RES_ZERO;
                        state_next    = S_EMIT;
                    end
                    OP_LOAD:
                    begin
                        priority if (sts.full)
                        begin
                            cmd.res_sel    = RES_ZERO;
                            cmd.res_status = ST_FULL;
                            state_next     = S_EMIT;
                        end
                        else if (sts.cnt_zero)
                        begin
                            state_next = S_LWRITE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_LAST;
                            state_next = S_LSQ;
                        end
                    end
                    default:
                    begin
                        if (sts.lt2)
                        begin
                            cmd.res_sel    = RES_ZERO;
                            cmd.res_status = ST_DEGEN;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_LAST;
                            state_next = S_ETOT;
                        end
                    end
                endcase
            end
            S_LSQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_LSUM;
            end
            S_LSUM:
            begin
                cmd.sum_init = 1'b1;
                state_next   = S_LSQRT;
            end
            S_LSQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = S_LWRITE;
                end
            end
            S_LWRITE:
            begin
                cmd.write_vtx = 1'b1;
                cmd.res_sel   = RES_ZERO;
                state_next    = S_EMIT;
            end
            S_ETOT:
            begin
                cmd.save_total = 1'b1;
                priority if (sts.total_zero)
                begin
                    cmd.res_sel    = RES_ZERO;
                    cmd.res_status = ST_DEGEN;
                    state_next     = S_EMIT;
                end
                else if (sts.t_zero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                    state_next = S_EVTX;
                end
                else if (sts.t_one)
                begin
                    cmd.res_sel = RES_VTX;
                    state_next  = S_EMIT;
                end
                else if (sts.op == OP_EVAL_IDX)
                begin
                    state_next = S_IMUL;
                end
                else
                begin
                    state_next = S_AMUL;
                end
            end
            S_IMUL:
            begin
                cmd.imul   = 1'b1;
                state_next = S_RLO;
            end
            S_AMUL:
            begin
                cmd.amul   = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (sts.target_ge)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = S_EVTX;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (sts.span_gt1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_SCMP;
                end
                else
                begin
                    state_next = S_RLO;
                end
            end
            S_SCMP:
            begin
                cmd.search_upd = 1'b1;
                state_next     = S_SRCH;
            end
            S_RLO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LO;
                state_next = S_RHI;
            end
            S_RHI:
            begin
                cmd.capture_a = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_HI;
                state_next    = (sts.op == OP_EVAL_IDX) ? S_MUL : S_ADIV0;
            end
            S_ADIV0:
            begin
                if (sts.seg_bad)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LO;
                    state_next = S_EVTX;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LERP;
            end
            S_LERP:
            begin
                cmd.res_sel = RES_LERP;
                state_next  = S_EMIT;
            end
            S_EVTX:
            begin
                cmd.res_sel = RES_VTX;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/polyline_arclength_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_arclength_sampler
// Polyline vertex table with index and arc-length point interpolation.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch (valid/ready); every item yields exactly one
// result transaction on out_ch. A clear item empties the table, a load item
// appends a vertex and its running length, and an evaluation item returns a
// point interpolated by index or by arc length.
// The block works on one item at a time. A load with a previous vertex runs
// the 33-step square root. An arc-length evaluation runs a binary search
// over the table, each probe waiting on the table RAM's registered read,
// and the 16-step divider; an index evaluation uses neither.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held back until the receiver takes it.
// Reset empties the table, clears reverse_direction and drops any pending
// result. The user must write the configuration register through
// cfg_write/cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module polyline_arclength_sampler (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_write,
    input  wire logic  cfg_data,
    pas_in_if.sink     in_ch,
    pas_out_if.source  out_ch
);
    import pas_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;
    logic       in_ready;

    // The sequencer accepts an item only in its idle state.
    assign in_ch.ready = in_ready;

    pas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the table, the arithmetic units and the result register.
    pas_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

[verif/polyline_arclength_sampler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_arclength_sampler_tb
// Self-checking bench for the polyline sampler: a directed table of clear,
// load and evaluation items, then random polylines with random positions,
// each result compared with a behavioral model of the table or a typed-in value.
// ----------------------------------------------------------------------------
module polyline_arclength_sampler_tb;
    import pas_pkg::*;

    // One row of the directed table. When has_exp is set the typed-in values
    // are what the result is compared against.
    typedef struct {
        op_t         op;
        logic [31:0] x;
        logic [31:0] y;
        logic [16:0] pos;
        bit          has_exp;
        logic [31:0] ex;
        logic [31:0] ey;
        status_t     est;
    } row_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        status_t     st;
    } point_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_data;

    pas_in_if  in_ch();
    pas_out_if out_ch();

    polyline_arclength_sampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Shadow copy of the block's state.
    logic signed [31:0] tbl_x [MAX_POINTS];
    logic signed [31:0] tbl_y [MAX_POINTS];
    logic [47:0]        tbl_len [MAX_POINTS];
    int unsigned        tbl_count;
    bit                 mirror_t;

    point_t pending_points[$];
    int     errors;
    int     results_seen;
    int     evals_sent;
    bit     stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor square root of a 66-bit sum of squares, one bit pair per step.
    function automatic logic [47:0] floor_sqrt(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return 48'(root);
    endfunction

    // a + (b - a) * f / 65536, rounded to nearest with halves going up.
    function automatic logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                          logic [15:0] f);
        logic signed [63:0] prod;
        prod = (64'(b) - 64'(a)) * $signed({48'd0, f}) + 64'sd32768;
        return 32'(64'(a) + (prod >>> 16));
    endfunction

    function automatic point_t vertex_at(int unsigned i);
        point_t p;
        p.x = tbl_x[i];
        p.y = tbl_y[i];
        p.st = ST_OK;
        return p;
    endfunction

    // Applies one item to the shadow table and returns the point it yields.
    function automatic point_t sample_polyline(op_t op, logic [31:0] x, logic [31:0] y,
                                               logic [16:0] pos);
        point_t      p;
        logic [47:0] total, dx, dy, seg, s0, den, target;
        logic [65:0] sq;
        logic [63:0] u;
        logic [63:0] frac;
        int unsigned n, i, lo, hi, mid;
        logic [16:0] t;
        p = '{32'd0, 32'd0, ST_OK};
        n = tbl_count;
        if (op == OP_CLEAR)
        begin
            tbl_count = 0;
            return p;
        end
        if (op == OP_LOAD)
        begin
            if (n >= MAX_POINTS)
            begin
                p.st = ST_FULL;
                return p;
            end
            total = '0;
            if (n > 0)
            begin
                dx = ($signed(x) >= tbl_x[n-1]) ? 48'(64'($signed(x)) - 64'(tbl_x[n-1]))
                                                : 48'(64'(tbl_x[n-1]) - 64'($signed(x)));
                dy = ($signed(y) >= tbl_y[n-1]) ? 48'(64'($signed(y)) - 64'(tbl_y[n-1]))
                                                : 48'(64'(tbl_y[n-1]) - 64'($signed(y)));
                sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
                seg = floor_sqrt(sq);
                total = (seg > LEN_MAX - tbl_len[n-1]) ? LEN_MAX : tbl_len[n-1] + seg;
            end
            tbl_x[n] = x;
            tbl_y[n] = y;
            tbl_len[n] = total;
            tbl_count = n + 1;
            return p;
        end
        if (n < 2 || tbl_len[n-1] == 0)
        begin
            p.st = ST_DEGEN;
            return p;
        end
        total = tbl_len[n-1];
        t = (pos > ONE_Q16) ? ONE_Q16 : pos;
        if (mirror_t)
            t = ONE_Q16 - t;
        if (t == 0)
            return vertex_at(0);
        if (t >= ONE_Q16)
            return vertex_at(n - 1);
        if (op == OP_EVAL_IDX)
        begin
            u = 64'(t) * 64'(n - 1);
            i = int'(u >> 16);
            if (i > n - 2)
                i = n - 2;
            p.x = blend(tbl_x[i], tbl_x[i+1], u[15:0]);
            p.y = blend(tbl_y[i], tbl_y[i+1], u[15:0]);
            return p;
        end
        target = 48'(64'(t) * 64'(total >> 16) + ((64'(t) * 64'(total[15:0])) >> 16));
        if (target >= total)
            return vertex_at(n - 1);
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (tbl_len[mid] <= target)
                lo = mid;
            else
                hi = mid;
        end
        s0 = tbl_len[lo];
        if (tbl_len[lo+1] <= s0 || target < s0)
            return vertex_at(lo);
        den = tbl_len[lo+1] - s0;
        frac = (64'(target - s0) << 16) / 64'(den);
        if (frac > 64'hFFFF)
            frac = 64'hFFFF;
        p.x = blend(tbl_x[lo], tbl_x[lo+1], frac[15:0]);
        p.y = blend(tbl_y[lo], tbl_y[lo+1], frac[15:0]);
        return p;
    endfunction

    // Sends one transaction after a random gap and records what it must yield.
    // Valid stays high after acceptance unless a gap follows or the run drains.
    task automatic send_item(op_t op, logic [31:0] x, logic [31:0] y, logic [16:0] pos);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.in_x     <= x;
        in_ch.in_y     <= y;
        in_ch.position <= pos;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_points.push_back(sample_polyline(op, x, y, pos));
        if (op == OP_EVAL_IDX || op == OP_EVAL_ARC)
            evals_sent++;
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_mirror(bit v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        mirror_t = v;
    endtask

    // The receiver stalls a random number of cycles per transaction, and
    // every result is compared against the oldest expected point.
    initial
    begin : result_checker
        int     stall;
        point_t want;
        out_ch.ready = 1'b0;
        errors = 0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            results_seen++;
            if (pending_points.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (out_ch.out_x !== want.x)
                begin
                    $error("out_x expected %h got %h", want.x, out_ch.out_x);
                    errors++;
                end
                if (out_ch.out_y !== want.y)
                begin
                    $error("out_y expected %h got %h", want.y, out_ch.out_y);
                    errors++;
                end
                if (out_ch.status !== want.st)
                begin
                    $error("status expected %0d got %0d", want.st, out_ch.status);
                    errors++;
                end
            end
        end
    end

    // Directed table: degenerate tables, extreme coordinates, clamping and
    // the ends of the position range.
    row_t plan [] = '{
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd32768, 1, 32'd0, 32'd0, ST_DEGEN},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd32768, 1, 32'd0, 32'd0, ST_DEGEN},
        '{OP_LOAD, 32'h8000_0000, 32'h8000_0000, 17'd0, 1, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd100, 1, 32'd0, 32'd0, ST_DEGEN},
        '{OP_LOAD, 32'h8000_0000, 32'h8000_0000, 17'd0, 1, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd100, 1, 32'd0, 32'd0, ST_DEGEN},
        '{OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0, 1, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd0, 1, 32'h8000_0000, 32'h8000_0000, ST_OK},
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd65536, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'h1FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd1, 0, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd65535, 0, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd40000, 0, 32'd0, 32'd0, ST_OK},
        '{OP_LOAD, 32'h0001_0000, 32'hFFFF_0000, 17'd0, 1, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_ARC, 32'd0, 32'd0, 17'd21845, 0, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd43690, 0, 32'd0, 32'd0, ST_OK},
        '{OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 1, 32'd0, 32'd0, ST_OK},
        '{OP_EVAL_IDX, 32'd0, 32'd0, 17'd32768, 1, 32'd0, 32'd0, ST_DEGEN}
    };

    initial
    begin : stimulus
        int          seg_count, long_runs;
        op_t         op;
        logic [31:0] x, y;
        logic [16:0] pos;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_CLEAR;
        in_ch.in_x = '0;
        in_ch.in_y = '0;
        in_ch.position = '0;
        tbl_count = 0;
        mirror_t = 1'b0;
        evals_sent = 0;
        stim_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mirroring is off after reset, so the typed-in ends hold as written.
        foreach (plan[r])
        begin
            send_item(plan[r].op, plan[r].x, plan[r].y, plan[r].pos);
            if (plan[r].has_exp)
            begin
                pending_points[$].x = plan[r].ex;
                pending_points[$].y = plan[r].ey;
                pending_points[$].st = plan[r].est;
            end
        end
        drain_block();

        // Fill the table to the top, then overfill it to hit the full status,
        // with mirrored positions evaluated on the longest table.
        write_mirror(1'b1);
        for (int k = 0; k < MAX_POINTS + 3; k++)
            send_item(OP_LOAD, $urandom, $urandom, '0);
        for (int k = 0; k < 20; k++)
            send_item(($urandom_range(0, 1) != 0) ? OP_EVAL_ARC : OP_EVAL_IDX,
                      '0, '0, 17'($urandom_range(0, 65536)));
        send_item(OP_CLEAR, '0, '0, '0);
        drain_block();

        // Random polylines: mostly short tables with random content, with
        // repeated vertices, odd positions and stray clears mixed in.
        long_runs = 0;
        while (long_runs < 100)
        begin
            if (long_runs % 25 == 12)
            begin
                drain_block();
                write_mirror(~mirror_t);
            end
            seg_count = $urandom_range(0, 9);
            send_item(OP_CLEAR, $urandom, $urandom, 17'($urandom));
            for (int k = 0; k < seg_count; k++)
            begin
                case ($urandom_range(0, 3))
                    0: begin x = $urandom; y = $urandom; end
                    1: begin x = 32'($urandom_range(0, 2000)) - 32'd1000; y = x; end
                    2: begin x = tbl_count != 0 ? tbl_x[tbl_count-1] : 32'd0;
                             y = tbl_count != 0 ? tbl_y[tbl_count-1] : 32'd0; end
                    default: begin x = $urandom & 32'h00FF_FFFF; y = $urandom; end
                endcase
                send_item(OP_LOAD, x, y, 17'($urandom));
            end
            for (int k = 0; k < 12; k++)
            begin
                op = ($urandom_range(0, 1) != 0) ? OP_EVAL_ARC : OP_EVAL_IDX;
                case ($urandom_range(0, 5))
                    0: pos = 17'($urandom);
                    1: pos = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
                    default: pos = 17'($urandom_range(0, 65536));
                endcase
                if ($urandom_range(0, 40) == 0)
                    op = OP_CLEAR;
                send_item(op, $urandom, $urandom, pos);
            end
            long_runs++;
        end
        drain_block();
        write_mirror(1'b0);
        stim_done = 1'b1;

        $display("Covered %0d evaluation items over directed tables, a full table and random",
                 evals_sent);
        $display("polylines in both directions; %0d result transactions checked.",
                 results_seen);
        if (errors == 0 && pending_points.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #60ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
